[hdl/hrsp_pkg.sv]
// types, codes and character constants shared by the request stream parser
`default_nettype none

package hrsp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        record_kind;
        logic [1:0]  status;
        logic [1:0]  method;
        logic [7:0]  ver_major;
        logic [7:0]  ver_minor;
        logic [15:0] uri_offset;
        logic [7:0]  uri_length;
        logic [5:0]  header_count;
        logic [15:0] start_offset;
        logic [15:0] name_length;
        logic [15:0] value_offset;
        logic [16:0] span_length;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_URI,
        PH_VERSION,
        PH_HEADER,
        PH_BODY,
        PH_IDLE
    } phase_t;

    typedef enum logic [3:0] {
        VS_H,
        VS_T1,
        VS_T2,
        VS_P,
        VS_SLASH,
        VS_MAJ_FIRST,
        VS_MAJ,
        VS_MIN_FIRST,
        VS_MIN,
        VS_TAIL,
        VS_FAIL
    } vstate_t;

    localparam logic       REC_HEADER  = 1'b0;
    localparam logic       REC_SUMMARY = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LINE = 2'd1;
    localparam logic [1:0] ST_NO_CRLF  = 2'd2;

    localparam logic [1:0] METH_NONE   = 2'd0;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // candidates in method code order: GET, POST, HEAD
    localparam logic [7:0] METHOD_NAME [3][4] = '{
        '{8'h47, 8'h45, 8'h54, 8'h00},
        '{8'h50, 8'h4F, 8'h53, 8'h54},
        '{8'h48, 8'h45, 8'h41, 8'h44}
    };
    localparam logic [2:0] METHOD_LEN [3] = '{3'd3, 3'd4, 3'd4};

endpackage

`default_nettype wire

[hdl/hrsp_parser.sv]
// per-byte parse state and the header and summary records each byte causes
`default_nettype none

module hrsp_parser #(
    parameter int BUF_MAX = 65536,
    parameter int URI_MAX = 256,
    parameter int HDR_MAX = 32
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    go,
    input  hrsp_pkg::in_item_t     item,
    output hrsp_pkg::out_item_t    rec0,
    output hrsp_pkg::out_item_t    rec1,
    output logic [1:0]             rec_cnt
);
    import hrsp_pkg::*;

    localparam int PW = $clog2(BUF_MAX + 1);
    localparam int UW = $clog2(URI_MAX);
    localparam int HW = $clog2(HDR_MAX + 1);

    typedef struct packed {
        phase_t          phase;
        logic [2:0]      mmatch;
        logic [2:0]      midx;
        logic [1:0]      method;
        logic [PW-1:0]   uri_off;
        logic [UW-1:0]   uri_count;
        vstate_t         vs;
        logic [7:0]      major;
        logic [7:0]      minor;
        logic [1:0]      status;
        logic [HW-1:0]   hdrs;
        logic [PW-1:0]   line_start;
        logic            colon_seen;
        logic [PW-1:0]   colon_pos;
        logic [PW-1:0]   value_start;
        logic            skipping;
        logic [PW-1:0]   body_off;
        logic [PW-1:0]   bpos;
        logic            prev_cr;
    } pstate_t;

    localparam pstate_t RESET_ST = '{
        phase:   PH_METHOD,
        mmatch:  3'b111,
        vs:      VS_H,
        status:  ST_NO_CRLF,
        default: '0
    };

    pstate_t st_reg;
    pstate_t st_next;

    pstate_t          s;
    logic [PW-1:0]    p;
    logic [PW-1:0]    c;
    logic             hdr_emit;
    out_item_t        hdr_rec;
    out_item_t        sum_rec;
    logic [PW-1:0]    boff;
    logic [PW-1:0]    blen;

    function automatic logic [7:0] sat_digit(logic [7:0] acc, logic [3:0] d);
        logic [11:0] v;
        v = 12'(acc) * 12'd10 + 12'(d);
        return (v > 12'd255) ? 8'hFF : v[7:0];
    endfunction

    function automatic pstate_t content(pstate_t si, logic [7:0] ch, logic [PW-1:0] pos);
        pstate_t    so;
        logic       dig;
        logic [1:0] res;
        so  = si;
        dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
        res = METH_NONE;
        case (si.phase)
            PH_METHOD:
            begin
                if (ch == CH_SP)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (si.mmatch[k] && (METHOD_LEN[k] == si.midx))
                        begin
                            res = 2'(k + 1);
                        end
                    end
                    so.method    = res;
                    so.phase     = PH_URI;
                    so.uri_off   = pos + PW'(1);
                    so.uri_count = '0;
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if ((si.midx >= METHOD_LEN[k]) ||
                            (METHOD_NAME[k][si.midx[1:0]] != ch))
                        begin
                            so.mmatch[k] = 1'b0;
                        end
                    end
                    if (si.midx != 3'd7)
                    begin
                        so.midx = si.midx + 3'd1;
                    end
                end
            end
            PH_URI:
            begin
                if (ch == CH_SP)
                begin
                    so.phase = PH_VERSION;
                    so.vs    = VS_H;
                end
                else if (si.uri_count < UW'(URI_MAX - 1))
                begin
                    so.uri_count = si.uri_count + UW'(1);
                end
            end
            PH_VERSION:
            begin
                unique case (si.vs)
                    VS_H:     so.vs = (ch == CH_H) ? VS_T1 : VS_FAIL;
                    VS_T1:    so.vs = (ch == CH_T) ? VS_T2 : VS_FAIL;
                    VS_T2:    so.vs = (ch == CH_T) ? VS_P : VS_FAIL;
                    VS_P:     so.vs = (ch == CH_P) ? VS_SLASH : VS_FAIL;
                    VS_SLASH: so.vs = (ch == CH_SLASH) ? VS_MAJ_FIRST : VS_FAIL;
                    VS_MAJ_FIRST:
                    begin
                        if (dig)
                        begin
                            so.major = 8'(ch[3:0]);
                            so.vs    = VS_MAJ;
                        end
                        else
                        begin
                            so.vs = VS_FAIL;
                        end
                    end
                    VS_MAJ:
                    begin
                        if (dig)
                        begin
                            so.major = sat_digit(si.major, ch[3:0]);
                        end
                        else
                        begin
                            so.vs = (ch == CH_DOT) ? VS_MIN_FIRST : VS_FAIL;
                        end
                    end
                    VS_MIN_FIRST:
                    begin
                        if (dig)
                        begin
                            so.minor = 8'(ch[3:0]);
                            so.vs    = VS_MIN;
                        end
                        else
                        begin
                            so.vs = VS_FAIL;
                        end
                    end
                    VS_MIN:
                    begin
                        if (dig)
                        begin
                            so.minor = sat_digit(si.minor, ch[3:0]);
                        end
                        else
                        begin
                            so.vs = VS_TAIL;
                        end
                    end
                    default: so.vs = si.vs;
                endcase
            end
            PH_HEADER:
            begin
                if (!si.colon_seen)
                begin
                    if (ch == CH_COLON)
                    begin
                        so.colon_seen  = 1'b1;
                        so.colon_pos   = pos;
                        so.value_start = pos + PW'(1);
                        so.skipping    = 1'b1;
                    end
                end
                else if (si.skipping)
                begin
                    if ((ch == CH_SP) || (ch == CH_TAB))
                    begin
                        so.value_start = pos + PW'(1);
                    end
                    else
                    begin
                        so.skipping = 1'b0;
                    end
                end
            end
            default: so = si;
        endcase
        return so;
    endfunction

    function automatic out_item_t make_rec(logic kind, pstate_t si, logic [PW-1:0] start,
                                           logic [PW-1:0] nlen, logic [PW-1:0] voff,
                                           logic [PW-1:0] span);
        out_item_t r;
        logic      ok;
        ok              = (si.status == ST_OK);
        r.record_kind   = kind;
        r.status        = si.status;
        r.method        = ok ? si.method : METH_NONE;
        r.ver_major     = ok ? si.major : 8'd0;
        r.ver_minor     = ok ? si.minor : 8'd0;
        r.uri_offset    = ok ? 16'(si.uri_off) : 16'd0;
        r.uri_length    = ok ? 8'(si.uri_count) : 8'd0;
        r.header_count  = ok ? 6'(si.hdrs) : 6'd0;
        r.start_offset  = ok ? 16'(start) : 16'd0;
        r.name_length   = 16'(nlen);
        r.value_offset  = 16'(voff);
        r.span_length   = ok ? 17'(span) : 17'd0;
        return r;
    endfunction

    always_comb
    begin
        s        = st_reg;
        p        = st_reg.bpos;
        c        = st_reg.bpos - PW'(1);
        hdr_emit = 1'b0;
        hdr_rec  = '0;
        boff     = '0;
        blen     = '0;
        if (st_reg.bpos < PW'(BUF_MAX))
        begin
            if ((s.phase != PH_BODY) && (s.phase != PH_IDLE))
            begin
                if (s.prev_cr && (item.data_byte == CH_LF))
                begin
                    s.prev_cr = 1'b0;
                    case (s.phase) inside
                        PH_METHOD, PH_URI:
                        begin
                            s.status = ST_BAD_LINE;
                            s.phase  = PH_IDLE;
                        end
                        PH_VERSION:
                        begin
                            if ((s.vs == VS_MIN) || (s.vs == VS_TAIL))
                            begin
                                s.status = ST_OK;
                                s.phase  = PH_HEADER;
                            end
                            else
                            begin
                                s.status = ST_BAD_LINE;
                                s.phase  = PH_IDLE;
                            end
                        end
                        PH_HEADER:
                        begin
                            if (c == s.line_start)
                            begin
                                s.phase    = PH_BODY;
                                s.body_off = c + PW'(2);
                            end
                            else if (s.colon_seen && (s.hdrs < HW'(HDR_MAX)))
                            begin
                                s.hdrs   = s.hdrs + HW'(1);
                                hdr_emit = 1'b1;
                                hdr_rec  = make_rec(REC_HEADER, s, s.line_start,
                                                    s.colon_pos - s.line_start,
                                                    s.value_start, c - s.value_start);
                            end
                        end
                        default: s.phase = s.phase;
                    endcase
                    s.line_start  = c + PW'(2);
                    s.colon_seen  = 1'b0;
                    s.skipping    = 1'b0;
                    s.colon_pos   = '0;
                    s.value_start = '0;
                end
                else
                begin
                    if (s.prev_cr)
                    begin
                        s.prev_cr = 1'b0;
                        s         = content(s, CH_CR, c);
                    end
                    if (item.data_byte == CH_CR)
                    begin
                        s.prev_cr = 1'b1;
                    end
                    else
                    begin
                        s = content(s, item.data_byte, p);
                    end
                end
            end
            s.bpos = p + PW'(1);
        end
        if ((s.phase == PH_BODY) && (s.bpos > s.body_off))
        begin
            boff = s.body_off;
            blen = s.bpos - s.body_off;
        end
        sum_rec = make_rec(REC_SUMMARY, s, boff, '0, '0, blen);
        st_next = item.last_byte ? RESET_ST : s;
    end

    always_comb
    begin
        rec0    = hdr_emit ? hdr_rec : sum_rec;
        rec1    = sum_rec;
        rec_cnt = 2'(hdr_emit) + 2'(item.last_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= RESET_ST;
        end
        else if (go)
        begin
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

[hdl/http_request_stream_parser.sv]
// top level: input register, request parser and two-entry record queue
// path: input register, parser, record queue; a byte's second record follows its first
// throughput: one byte per cycle while records are taken; a stalled output backs the input up
//   once the two-entry record queue cannot hold the records of the waiting byte
// reset: rst_n clears the input valid flag, the queue count and the parse state at once;
//   the parse state also returns to its reset values after every final byte
`default_nettype none

module http_request_stream_parser #(
    parameter int BUF_MAX = 65536,
    parameter int URI_MAX = 256,
    parameter int HDR_MAX = 32
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    byte_valid,
    output logic                   byte_stall,
    input  hrsp_pkg::in_item_t     byte_item,
    output logic                   rec_valid,
    input  wire                    rec_stall,
    output hrsp_pkg::out_item_t    rec_item
);
    import hrsp_pkg::*;

    logic       in_vld_reg;
    in_item_t   in_reg;
    out_item_t  q0_reg;
    out_item_t  q0_next;
    out_item_t  q1_reg;
    out_item_t  q1_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    out_item_t  rec0;
    out_item_t  rec1;
    logic [1:0] rec_cnt;
    logic       pop;
    logic       go;
    logic [1:0] base_cnt;
    out_item_t  base0;

    hrsp_parser #(
        .BUF_MAX (BUF_MAX),
        .URI_MAX (URI_MAX),
        .HDR_MAX (HDR_MAX)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .item    (in_reg),
        .rec0    (rec0),
        .rec1    (rec1),
        .rec_cnt (rec_cnt)
    );

    assign rec_valid  = (cnt_reg != 2'd0);
    assign rec_item   = q0_reg;
    assign pop        = rec_valid && !rec_stall;
    assign base_cnt   = cnt_reg - 2'(pop);
    assign base0      = pop ? q1_reg : q0_reg;
    assign go         = in_vld_reg && ((3'(base_cnt) + 3'(rec_cnt)) <= 3'd2);
    assign byte_stall = in_vld_reg && !go;

    always_comb
    begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = base_cnt;
        case (base_cnt)
            2'd0:
            begin
                q0_next = rec0;
                q1_next = rec1;
            end
            2'd1:
            begin
                q0_next = base0;
                q1_next = rec0;
            end
            default:
            begin
                q0_next = q0_reg;
                q1_next = q1_reg;
            end
        endcase
        if (go)
        begin
            cnt_next = base_cnt + rec_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (!byte_stall)
            begin
                in_vld_reg <= byte_valid;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_reg <= byte_item;
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

`default_nettype wire

[hdl/hrsp_checker.sv]
// port-level checks on the record stream, bound to the top level
`default_nettype none

module hrsp_checker (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    rec_valid,
    input  wire                    rec_stall,
    input  hrsp_pkg::out_item_t    rec_item
);
    import hrsp_pkg::*;

    // a stalled record holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_stall |=> rec_valid && $stable(rec_item))
        else $error("record changed while stalled");

    // header records only follow a good request line and are counted
    a_hdr_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && (rec_item.record_kind == REC_HEADER) |->
            (rec_item.status == ST_OK) && (rec_item.header_count != 6'd0))
        else $error("header record with bad status");

    // a failed summary carries no parse results
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && (rec_item.status != ST_OK) |->
            (rec_item.record_kind == REC_SUMMARY) && (rec_item.method == METH_NONE) &&
            (rec_item.header_count == 6'd0) && (rec_item.span_length == 17'd0) &&
            (rec_item.uri_length == 8'd0))
        else $error("failed summary carries parse results");

    // status never takes the unused code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |-> (rec_item.status == ST_OK) || (rec_item.status == ST_BAD_LINE) ||
            (rec_item.status == ST_NO_CRLF))
        else $error("record status out of range");

endmodule

bind http_request_stream_parser hrsp_checker u_hrsp_checker (.*);

`default_nettype wire

[sim/tb_http_request_stream_parser.sv]
// testbench for the request stream parser: byte driver, record monitor and a parsing predictor
`timescale 1ns / 100ps

module tb_http_request_stream_parser;

    import hrsp_pkg::*;

    localparam int BUF_MAX     = 65536;
    localparam int URI_MAX     = 256;
    localparam int HDR_MAX     = 32;
    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        in_item_t    item;
        int unsigned gap;
    } send_slot_t;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_stall;
    in_item_t  byte_item  = '0;
    logic      rec_valid;
    logic      rec_stall  = 1'b0;
    out_item_t rec_item;

    logic [7:0]  req[$];
    send_slot_t  outgoing[$];
    out_item_t   records_due[$];

    bit          byte_taken, rec_taken, squeezed;
    int unsigned bytes_in, records_seen, mismatches, quiet_cycles;
    int unsigned send_wait, recv_wait, hold_left;

    // predictor state
    phase_t      ph;
    vstate_t     vst;
    logic [2:0]  cand;
    logic [1:0]  meth, req_st;
    bit          prev_cr, colon_seen, skip_sp;
    int unsigned pos, meth_idx, uri_at, uri_len, maj, minr, hdr_cnt;
    int unsigned ln_start, colon_at, val_at, body_at;

    http_request_stream_parser #(
        .BUF_MAX (BUF_MAX),
        .URI_MAX (URI_MAX),
        .HDR_MAX (HDR_MAX)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .rec_valid  (rec_valid),
        .rec_stall  (rec_stall),
        .rec_item   (rec_item)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void clear_parse();
        ph         = PH_METHOD;
        vst        = VS_H;
        cand       = 3'b111;
        meth       = METH_NONE;
        req_st     = ST_NO_CRLF;
        prev_cr    = 1'b0;
        colon_seen = 1'b0;
        skip_sp    = 1'b0;
        pos        = 0;
        meth_idx   = 0;
        uri_at     = 0;
        uri_len    = 0;
        maj        = 0;
        minr       = 0;
        hdr_cnt    = 0;
        ln_start   = 0;
        colon_at   = 0;
        val_at     = 0;
        body_at    = 0;
    endfunction

    function automatic int unsigned saturate_digit(int unsigned acc, int unsigned d);
        int unsigned v;
        v = acc * 10 + d;
        return (v > 255) ? 255 : v;
    endfunction

    function automatic out_item_t make_record(logic kind, logic [1:0] st, int unsigned start,
                                              int unsigned nlen, int unsigned voff,
                                              int unsigned span);
        out_item_t r;
        bit        ok;
        ok              = (st == ST_OK);
        r.record_kind   = kind;
        r.status        = st;
        r.method        = ok ? meth : METH_NONE;
        r.ver_major     = ok ? 8'(maj) : 8'd0;
        r.ver_minor     = ok ? 8'(minr) : 8'd0;
        r.uri_offset    = ok ? 16'(uri_at) : 16'd0;
        r.uri_length    = ok ? 8'(uri_len) : 8'd0;
        r.header_count  = ok ? 6'(hdr_cnt) : 6'd0;
        r.start_offset  = ok ? 16'(start) : 16'd0;
        r.name_length   = 16'(nlen);
        r.value_offset  = 16'(voff);
        r.span_length   = ok ? 17'(span) : 17'd0;
        return r;
    endfunction

    function automatic void step_version(logic [7:0] c);
        bit          dig;
        int unsigned d;
        dig = (c >= CH_ZERO && c <= CH_NINE);
        d   = 32'(c - CH_ZERO);
        case (vst)
            VS_H:     vst = (c == CH_H) ? VS_T1 : VS_FAIL;
            VS_T1:    vst = (c == CH_T) ? VS_T2 : VS_FAIL;
            VS_T2:    vst = (c == CH_T) ? VS_P : VS_FAIL;
            VS_P:     vst = (c == CH_P) ? VS_SLASH : VS_FAIL;
            VS_SLASH: vst = (c == CH_SLASH) ? VS_MAJ_FIRST : VS_FAIL;
            VS_MAJ_FIRST:
            begin
                if (dig)
                begin
                    maj = d;
                    vst = VS_MAJ;
                end
                else
                    vst = VS_FAIL;
            end
            VS_MAJ:
            begin
                if (dig)
                    maj = saturate_digit(maj, d);
                else
                    vst = (c == CH_DOT) ? VS_MIN_FIRST : VS_FAIL;
            end
            VS_MIN_FIRST:
            begin
                if (dig)
                begin
                    minr = d;
                    vst  = VS_MIN;
                end
                else
                    vst = VS_FAIL;
            end
            VS_MIN:
            begin
                if (dig)
                    minr = saturate_digit(minr, d);
                else
                    vst = VS_TAIL;
            end
            default: ;
        endcase
    endfunction

    function automatic void take_byte(logic [7:0] c, int unsigned p);
        case (ph)
            PH_METHOD:
            begin
                if (c == CH_SP)
                begin
                    meth = METH_NONE;
                    for (int k = 0; k < 3; k++)
                        if (cand[k] && METHOD_LEN[k] == meth_idx)
                            meth = 2'(k + 1);
                    ph      = PH_URI;
                    uri_at  = p + 1;
                    uri_len = 0;
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                        if (meth_idx >= METHOD_LEN[k] || METHOD_NAME[k][meth_idx % 4] != c)
                            cand[k] = 1'b0;
                    if (meth_idx < 7)
                        meth_idx++;
                end
            end
            PH_URI:
            begin
                if (c == CH_SP)
                begin
                    ph  = PH_VERSION;
                    vst = VS_H;
                end
                else if (uri_len < URI_MAX - 1)
                    uri_len++;
            end
            PH_VERSION:
                step_version(c);
            PH_HEADER:
            begin
                if (!colon_seen)
                begin
                    if (c == CH_COLON)
                    begin
                        colon_seen = 1'b1;
                        colon_at   = p;
                        val_at     = p + 1;
                        skip_sp    = 1'b1;
                    end
                end
                else if (skip_sp)
                begin
                    if (c == CH_SP || c == CH_TAB)
                        val_at = p + 1;
                    else
                        skip_sp = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    // c is the position of the cr of the line end
    function automatic void end_line(int unsigned c);
        case (ph) inside
            PH_METHOD, PH_URI:
            begin
                req_st = ST_BAD_LINE;
                ph     = PH_IDLE;
            end
            PH_VERSION:
            begin
                if (vst == VS_MIN || vst == VS_TAIL)
                begin
                    req_st = ST_OK;
                    ph     = PH_HEADER;
                end
                else
                begin
                    req_st = ST_BAD_LINE;
                    ph     = PH_IDLE;
                end
            end
            PH_HEADER:
            begin
                if (c == ln_start)
                begin
                    ph      = PH_BODY;
                    body_at = c + 2;
                end
                else if (colon_seen && hdr_cnt < HDR_MAX)
                begin
                    hdr_cnt++;
                    records_due.push_back(make_record(REC_HEADER, ST_OK, ln_start,
                                                      colon_at - ln_start, val_at, c - val_at));
                end
            end
            default: ;
        endcase
        ln_start   = c + 2;
        colon_seen = 1'b0;
        skip_sp    = 1'b0;
        colon_at   = 0;
        val_at     = 0;
    endfunction

    function automatic void parse_byte(in_item_t it);
        logic [7:0]  b;
        int unsigned p, boff, blen;
        b = it.data_byte;
        if (pos < BUF_MAX)
        begin
            p = pos;
            if (ph != PH_BODY && ph != PH_IDLE)
            begin
                if (prev_cr && b == CH_LF)
                begin
                    prev_cr = 1'b0;
                    end_line(p - 1);
                end
                else
                begin
                    if (prev_cr)
                    begin
                        prev_cr = 1'b0;
                        take_byte(CH_CR, p - 1);
                    end
                    if (b == CH_CR)
                        prev_cr = 1'b1;
                    else
                        take_byte(b, p);
                end
            end
            pos = p + 1;
        end
        if (it.last_byte)
        begin
            boff = 0;
            blen = 0;
            if (ph == PH_BODY && pos > body_at)
            begin
                boff = body_at;
                blen = pos - body_at;
            end
            records_due.push_back(make_record(REC_SUMMARY, req_st, boff, 0, 0, blen));
            clear_parse();
        end
    endfunction

    function automatic string show(out_item_t r);
        return $sformatf({"kind=%0d st=%0d meth=%0d ver=%0d.%0d uri=%0d/%0d hdrs=%0d ",
                          "start=%0d name=%0d val=%0d span=%0d"},
                         r.record_kind, r.status, r.method, r.ver_major, r.ver_minor,
                         r.uri_offset, r.uri_length, r.header_count, r.start_offset,
                         r.name_length, r.value_offset, r.span_length);
    endfunction

    function automatic string differing_fields(out_item_t a, out_item_t b);
        string s = "";
        if (a.record_kind !== b.record_kind)     s = {s, " record_kind"};
        if (a.status !== b.status)               s = {s, " status"};
        if (a.method !== b.method)               s = {s, " method"};
        if (a.ver_major !== b.ver_major)         s = {s, " ver_major"};
        if (a.ver_minor !== b.ver_minor)         s = {s, " ver_minor"};
        if (a.uri_offset !== b.uri_offset)       s = {s, " uri_offset"};
        if (a.uri_length !== b.uri_length)       s = {s, " uri_length"};
        if (a.header_count !== b.header_count)   s = {s, " header_count"};
        if (a.start_offset !== b.start_offset)   s = {s, " start_offset"};
        if (a.name_length !== b.name_length)     s = {s, " name_length"};
        if (a.value_offset !== b.value_offset)   s = {s, " value_offset"};
        if (a.span_length !== b.span_length)     s = {s, " span_length"};
        return s;
    endfunction

    function automatic void check_record(out_item_t got);
        out_item_t want;
        string     bad;
        records_seen++;
        if (records_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("record %0d not expected: %s", records_seen, show(got));
        end
        else
        begin
            want = records_due.pop_front();
            bad  = differing_fields(want, got);
            if (bad != "")
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("record %0d differs in%s\n  expected %s\n  actual   %s",
                             records_seen, bad, show(want), show(got));
            end
        end
    endfunction

    // stimulus assembly
    function automatic void put_byte(logic [7:0] b);
        req.push_back(b);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endfunction

    function automatic void put_crlf();
        put_byte(CH_CR);
        put_byte(CH_LF);
    endfunction

    function automatic void put_digits();
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2))
            put_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
    endfunction

    function automatic void queue_request(bit steady);
        send_slot_t slot;
        foreach (req[i])
        begin
            slot.item.data_byte = req[i];
            slot.item.last_byte = (i == req.size() - 1);
            slot.gap            = steady ? 0 : $urandom_range(0, 3);
            outgoing.push_back(slot);
        end
        req.delete();
    endfunction

    function automatic void build_random_request();
        bit          tidy;
        int unsigned n, pick, cut;
        tidy = ($urandom_range(0, 5) != 0);
        pick = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        case (pick)
            0: put_text("GET");
            1: put_text("POST");
            2: put_text("HEAD");
            3: put_text("GE");
            4: put_text("GETS");
            5: put_text("PUT");
            6: put_text("HEA");
            7: put_text("get");
            default: repeat ($urandom_range(0, 5)) put_byte(8'($urandom_range(65, 90)));
        endcase
        if (tidy || $urandom_range(0, 1))
            put_byte(CH_SP);
        n = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 12);
        put_byte(CH_SLASH);
        repeat (n) put_byte(8'($urandom_range(33, 126)));
        if (tidy || $urandom_range(0, 1))
            put_byte(CH_SP);
        if (tidy)
        begin
            put_text("HTTP/");
            put_digits();
            put_byte(CH_DOT);
            put_digits();
            if ($urandom_range(0, 5) == 0)
                put_text("x1");
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: put_text("HTTP/1");
                1: put_text("HTTP/.1");
                2: put_text("HTP/1.1");
                default: repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(32, 126)));
            endcase
        end
        if (tidy || $urandom_range(0, 1))
            put_crlf();
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(33, 36) : $urandom_range(0, 5);
        repeat (n)
        begin
            repeat ($urandom_range(0, 8)) put_byte(8'($urandom_range(97, 122)));
            if ($urandom_range(0, 7) != 0)
            begin
                put_byte(CH_COLON);
                repeat ($urandom_range(0, 2)) put_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
                repeat ($urandom_range(0, 10)) put_byte(8'($urandom_range(32, 126)));
            end
            if ($urandom_range(0, 19) == 0)
                put_byte(8'($urandom_range(0, 255)));
            put_crlf();
        end
        if ($urandom_range(0, 4) != 0)
        begin
            put_crlf();
            repeat ($urandom_range(0, 24)) put_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0)
        begin
            cut = $urandom_range(1, req.size());
            req = req[0:cut-1];
        end
        if (req.size() == 0)
            put_byte(8'($urandom_range(0, 255)));
    endfunction

    // sampling, prediction, checking and watchdog count
    always @(posedge clk)
    begin
        rec_taken  = rst_n && rec_valid && !rec_stall;
        byte_taken = rst_n && byte_valid && !byte_stall;
        if (rec_taken)
            check_record(rec_item);
        if (byte_taken)
        begin
            parse_byte(byte_item);
            bytes_in++;
        end
        if (rec_taken || byte_taken)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    always @(negedge clk)
    begin : drive_bytes
        send_slot_t slot;
        if (rst_n && (!byte_valid || byte_taken))
        begin
            if (send_wait > 0)
            begin
                byte_valid <= 1'b0;
                send_wait  <= send_wait - 1;
            end
            else if (outgoing.size() > 0)
            begin
                slot = outgoing.pop_front();
                byte_item  <= slot.item;
                byte_valid <= 1'b1;
                send_wait  <= slot.gap;
            end
            else
                byte_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // one long hold-off so the record queue fills and the input backs up
            if (!squeezed && records_seen >= 30)
            begin
                squeezed  = 1'b1;
                hold_left = 300;
            end
            if (rec_taken)
                recv_wait = (records_seen % 50 < 12) ? 0 : $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                rec_stall <= 1'b1;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                rec_stall <= 1'b1;
            end
            else
                rec_stall <= 1'b0;
        end
    end

    initial
    begin : run
        int unsigned total_bytes;
        bit          stuck;
        clear_parse();

        put_text("GET /a HTTP/1.1");
        put_crlf();
        put_text("Host:  \t v");
        put_crlf();
        put_crlf();
        put_text("body");
        queue_request(1'b0);
        // final byte closes a header line: header then summary
        put_text("POST / HTTP/999.12345");
        put_crlf();
        put_text("k: \t");
        put_crlf();
        queue_request(1'b0);
        put_text("HEAD x HTTP/0.0junk");
        put_crlf();
        put_crlf();
        queue_request(1'b0);
        put_text("GETX / HTTP/1.1");
        put_crlf();
        put_text(":v");
        put_crlf();
        put_crlf();
        put_byte(8'h00);
        queue_request(1'b0);
        put_text("GET");
        put_crlf();
        put_text("A:b");
        put_crlf();
        queue_request(1'b0);
        put_text("GET ");
        put_crlf();
        queue_request(1'b0);
        put_text("GET /");
        put_crlf();
        queue_request(1'b0);
        put_text("GET / HTTX/1.1");
        put_crlf();
        put_text("A:b");
        put_crlf();
        queue_request(1'b0);
        put_text("GET / HTTP/1.");
        put_crlf();
        queue_request(1'b0);
        // empty uri, colonless line, lone cr, nul and an unterminated header
        put_text("GET  HTTP/1.1");
        put_crlf();
        put_text("no colon");
        put_crlf();
        put_text("A");
        put_byte(CH_CR);
        put_text("B:c");
        put_byte(CH_CR);
        put_crlf();
        put_text("D:");
        put_byte(8'h00);
        put_text("e");
        put_crlf();
        put_text("partial:x");
        queue_request(1'b0);
        put_text("GET / HTTP/1.1");
        queue_request(1'b0);
        put_byte(8'hFF);
        queue_request(1'b0);
        put_byte(8'h00);
        queue_request(1'b0);
        // clipped uri and more header lines than the block keeps
        put_text("POST /");
        repeat (300) put_byte(8'($urandom_range(33, 126)));
        put_text(" HTTP/1.0");
        put_crlf();
        repeat (34)
        begin
            put_text("h:v");
            put_crlf();
        end
        put_crlf();
        queue_request(1'b0);

        while (outgoing.size() < 1400)
        begin
            build_random_request();
            queue_request($urandom_range(0, 3) == 0);
        end

        total_bytes = outgoing.size();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        stuck = 1'b0;
        while (!stuck && !(bytes_in == total_bytes && records_due.size() == 0))
        begin
            @(negedge clk);
            stuck = (quiet_cycles >= QUIET_LIMIT);
        end
        if (stuck)
            $display("*** FAILED ***");
        else
        begin
            repeat (8) @(posedge clk);
            @(negedge clk);
            if (records_due.size() != 0)
            begin
                mismatches++;
                $display("%0d records never arrived", records_due.size());
            end
            if (mismatches == 0)
                $display("*** PASSED ***");
            else
                $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/hrsp_pkg.sv
hdl/hrsp_parser.sv
hdl/http_request_stream_parser.sv
hdl/hrsp_checker.sv
sim/tb_http_request_stream_parser.sv
